>>> rtl/core/cttok_pkg.sv
// ----------------------------------------------------------------------------
// Command text tokenizer package
// Shared widths, token kinds, character codes and the queue entry layout.
// ----------------------------------------------------------------------------
package cttok_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int LINE_BITS   = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_CMD     = 4'd1,
    KIND_STR     = 4'd2,
    KIND_INT     = 4'd3,
    KIND_FLT     = 4'd4,
    KIND_OPEN    = 4'd5,
    KIND_CLOSE   = 4'd6,
    KIND_COMMA   = 4'd7,
    KIND_TRUE    = 4'd8,
    KIND_FALSE   = 4'd9,
    KIND_COMMENT = 4'd10
  } kind_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    kind_e                  kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   row;
    logic [LINE_BITS-1:0]   col;
  } tok_t;

  // One byte yields at most two tokens; they travel together.
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } pair_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_decimal(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c inside {["0":"9"], ["a":"z"], ["A":"Z"]}) || (c == "_");
  endfunction

  // Keyword text, zero past the end of each word.
  function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [39:0] w;
    logic [7:0]  r;
    case (idx)
      2'd0:    w = {"true", 8'h00};
      2'd1:    w = {"True", 8'h00};
      2'd2:    w = "false";
      default: w = "False";
    endcase
    if (pos > 3'd4) begin
      r = 8'h00;
    end else begin
      r = w[(32 - 8 * int'(pos)) +: 8];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/command_text_tokenizer_core.sv
// A token is written into the queue at the edge that accepts the byte ending it,
// then loaded into the output stage register that drives the result ports.
// Throughput: one byte per cycle while the 4-entry queue has room; a full queue
// holds off the input. A byte may close one token and open another, so two tokens
// can share one slot; tokens leave at most one per cycle.
// Reset (rst_ni low, asynchronous) clears the scanner to row 1, column 1, offset 0.
// ----------------------------------------------------------------------------
// Command text tokenizer
// Streaming lexer: one text byte in, token kind and position records out.
// ----------------------------------------------------------------------------
module command_text_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind_o,
  output logic [19:0] start_offset_o,
  output logic [19:0] token_length_o,
  output logic [15:0] start_row_o,
  output logic [15:0] start_col_o,
  output logic        last_of_run_o
);

  logic             accept;
  logic             pair_valid;
  cttok_pkg::pair_t pair;
  logic             fifo_full, fifo_empty, fifo_pop;
  cttok_pkg::pair_t fifo_data;
  cttok_pkg::tok_t  tok;

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  cttok_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (text_byte_i),
    .pair_valid_o (pair_valid),
    .pair_o       (pair)
  );

  cttok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pair_valid),
    .data_i  (pair),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_data)
  );

  cttok_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_data),
    .fifo_pop_o   (fifo_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .tok_o        (tok),
    .last_o       (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign start_row_o    = tok.row;
  assign start_col_o    = tok.col;

endmodule

>>> rtl/core/cttok_scan.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classifies each byte against the scanner state and forms finished tokens.
// ----------------------------------------------------------------------------
module cttok_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  output logic             pair_valid_o,
  output cttok_pkg::pair_t pair_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_CMD,
    MODE_STR,
    MODE_INT,
    MODE_FRAC,
    MODE_WORD,
    MODE_COMMENT
  } mode_e;

  mode_e mode_q, mode_d;
  logic esc_q, esc_d;
  logic [3:0] cand_q, cand_d;
  logic [2:0] run_q, run_d;
  logic [cttok_pkg::OFFSET_BITS-1:0] tstart_q, tstart_d;
  logic [cttok_pkg::OFFSET_BITS-1:0] tcnt_q, tcnt_d;
  logic [cttok_pkg::OFFSET_BITS-1:0] off_q, off_d;
  logic [cttok_pkg::LINE_BITS-1:0] trow_q, trow_d, tcol_q, tcol_d;
  logic [cttok_pkg::LINE_BITS-1:0] line_q, line_d, col_q, col_d;
  logic fin_q, fin_d;

  logic [cttok_pkg::OFFSET_BITS-1:0] off_inc, tcnt_inc;
  logic [cttok_pkg::LINE_BITS-1:0] line_inc, col_inc;
  logic word_true, word_false;

  logic end_emit, st_emit, consume, dispatch, comment_chk, begin_tok;
  cttok_pkg::kind_e end_kind, st_kind;
  logic [cttok_pkg::OFFSET_BITS-1:0] end_len, st_len;
  cttok_pkg::tok_t end_tok, st_tok;

  function automatic logic [3:0] narrow(input logic [3:0] cand, input logic [2:0] run,
                                        input logic [7:0] c);
    logic [3:0] keep;
    for (int i = 0; i < 4; i++) begin
      keep[i] = cand[i] && (cttok_pkg::kw_char(2'(i), run) == c);
    end
    return keep;
  endfunction

  assign off_inc  = (off_q == cttok_pkg::OFF_MAX) ? off_q : off_q + 1'b1;
  assign tcnt_inc = (tcnt_q == cttok_pkg::OFF_MAX) ? tcnt_q : tcnt_q + 1'b1;
  assign line_inc = (line_q == cttok_pkg::LINE_MAX) ? line_q : line_q + 1'b1;
  assign col_inc  = (col_q == cttok_pkg::LINE_MAX) ? col_q : col_q + 1'b1;

  // A word is a keyword only when a candidate survives to exactly its length.
  assign word_true  = (cand_q[0] | cand_q[1]) && (run_q == 3'd4);
  assign word_false = (cand_q[2] | cand_q[3]) && (run_q == 3'd5);

  always_comb begin
    mode_d = mode_q;
    esc_d = esc_q;
    cand_d = cand_q;
    run_d = run_q;
    tstart_d = tstart_q;
    tcnt_d = tcnt_q;
    off_d = off_q;
    trow_d = trow_q;
    tcol_d = tcol_q;
    line_d = line_q;
    col_d = col_q;
    fin_d = fin_q;
    end_emit = 1'b0;
    end_kind = cttok_pkg::KIND_END;
    end_len = tcnt_q;
    st_emit = 1'b0;
    st_kind = cttok_pkg::KIND_END;
    st_len = '0;
    consume = 1'b0;
    dispatch = 1'b0;
    comment_chk = 1'b0;
    begin_tok = 1'b0;

    if (accept_i && !fin_q) begin
      case (mode_q)
        MODE_CMD: begin
          if (cttok_pkg::is_sym(byte_i)) begin
            consume = 1'b1;
          end else begin
            end_emit = 1'b1;
            end_kind = cttok_pkg::KIND_CMD;
            dispatch = 1'b1;
          end
        end
        MODE_STR: begin
          if (byte_i == cttok_pkg::CH_NUL) begin
            end_emit = 1'b1;
            end_kind = cttok_pkg::KIND_STR;
            dispatch = 1'b1;
          end else if (esc_q) begin
            esc_d = 1'b0;
            consume = 1'b1;
          end else if (byte_i == cttok_pkg::CH_BSLASH) begin
            esc_d = 1'b1;
            consume = 1'b1;
          end else begin
            consume = 1'b1;
            if (byte_i == cttok_pkg::CH_QUOTE) begin
              // The closing quote counts toward the length.
              end_emit = 1'b1;
              end_kind = cttok_pkg::KIND_STR;
              end_len = tcnt_inc;
              mode_d = MODE_IDLE;
            end
          end
        end
        MODE_INT: begin
          if (cttok_pkg::is_decimal(byte_i)) begin
            consume = 1'b1;
          end else if (byte_i == cttok_pkg::CH_DOT) begin
            mode_d = MODE_FRAC;
            consume = 1'b1;
          end else begin
            end_emit = 1'b1;
            end_kind = cttok_pkg::KIND_INT;
            dispatch = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (cttok_pkg::is_decimal(byte_i)) begin
            consume = 1'b1;
          end else begin
            end_emit = 1'b1;
            end_kind = cttok_pkg::KIND_FLT;
            dispatch = 1'b1;
          end
        end
        MODE_WORD: begin
          if (cttok_pkg::is_sym(byte_i)) begin
            consume = 1'b1;
            cand_d = narrow(cand_q, run_q, byte_i);
            run_d = (run_q == 3'd7) ? run_q : run_q + 3'd1;
          end else if (word_true) begin
            end_emit = 1'b1;
            end_kind = cttok_pkg::KIND_TRUE;
            dispatch = 1'b1;
          end else if (word_false) begin
            end_emit = 1'b1;
            end_kind = cttok_pkg::KIND_FALSE;
            dispatch = 1'b1;
          end else begin
            comment_chk = 1'b1;
          end
        end
        MODE_COMMENT: begin
          comment_chk = 1'b1;
        end
        default: begin
          dispatch = 1'b1;
        end
      endcase

      if (comment_chk) begin
        if (byte_i != cttok_pkg::CH_NUL && !cttok_pkg::is_space(byte_i)) begin
          mode_d = MODE_COMMENT;
          consume = 1'b1;
        end else begin
          end_emit = 1'b1;
          end_kind = cttok_pkg::KIND_COMMENT;
          dispatch = 1'b1;
        end
      end

      // The byte that ended a token, or any byte between tokens, opens what follows.
      if (dispatch) begin
        mode_d = MODE_IDLE;
        if (byte_i == cttok_pkg::CH_NUL) begin
          st_emit = 1'b1;
          st_kind = cttok_pkg::KIND_END;
          fin_d = 1'b1;
        end else if (cttok_pkg::is_space(byte_i)) begin
          consume = 1'b1;
        end else begin
          begin_tok = 1'b1;
          consume = 1'b1;
          tstart_d = off_q;
          trow_d = line_q;
          tcol_d = col_q;
          esc_d = 1'b0;
          cand_d = 4'hF;
          run_d = 3'd0;
          if (byte_i == cttok_pkg::CH_BANG) begin
            mode_d = MODE_CMD;
          end else if (byte_i == cttok_pkg::CH_QUOTE) begin
            mode_d = MODE_STR;
          end else if (byte_i == cttok_pkg::CH_OPEN) begin
            st_emit = 1'b1;
            st_kind = cttok_pkg::KIND_OPEN;
            st_len = cttok_pkg::OFFSET_BITS'(1);
          end else if (byte_i == cttok_pkg::CH_CLOSE) begin
            st_emit = 1'b1;
            st_kind = cttok_pkg::KIND_CLOSE;
            st_len = cttok_pkg::OFFSET_BITS'(1);
          end else if (byte_i == cttok_pkg::CH_COMMA) begin
            st_emit = 1'b1;
            st_kind = cttok_pkg::KIND_COMMA;
            st_len = cttok_pkg::OFFSET_BITS'(1);
          end else if (cttok_pkg::is_decimal(byte_i)) begin
            mode_d = MODE_INT;
          end else if (byte_i == cttok_pkg::CH_DOT) begin
            mode_d = MODE_FRAC;
          end else if (cttok_pkg::is_sym(byte_i)) begin
            mode_d = MODE_WORD;
            cand_d = narrow(4'hF, 3'd0, byte_i);
            run_d = 3'd1;
          end else begin
            mode_d = MODE_COMMENT;
          end
        end
      end

      if (consume) begin
        off_d = off_inc;
        tcnt_d = begin_tok ? cttok_pkg::OFFSET_BITS'(1) : tcnt_inc;
        if (byte_i == cttok_pkg::CH_NL) begin
          line_d = line_inc;
          col_d = cttok_pkg::LINE_BITS'(1);
        end else begin
          col_d = col_inc;
        end
      end
    end
  end

  always_comb begin
    end_tok.kind  = end_kind;
    end_tok.start = tstart_q;
    end_tok.len   = end_len;
    end_tok.row   = trow_q;
    end_tok.col   = tcol_q;
    st_tok.kind   = st_kind;
    st_tok.start  = off_q;
    st_tok.len    = st_len;
    st_tok.row    = line_q;
    st_tok.col    = col_q;
    pair_o.two    = end_emit & st_emit;
    pair_o.first  = end_emit ? end_tok : st_tok;
    pair_o.second = st_tok;
  end

  assign pair_valid_o = end_emit | st_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      esc_q <= 1'b0;
      cand_q <= 4'hF;
      run_q <= 3'd0;
      tstart_q <= '0;
      tcnt_q <= '0;
      off_q <= '0;
      trow_q <= cttok_pkg::LINE_BITS'(1);
      tcol_q <= cttok_pkg::LINE_BITS'(1);
      line_q <= cttok_pkg::LINE_BITS'(1);
      col_q <= cttok_pkg::LINE_BITS'(1);
      fin_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      esc_q <= esc_d;
      cand_q <= cand_d;
      run_q <= run_d;
      tstart_q <= tstart_d;
      tcnt_q <= tcnt_d;
      off_q <= off_d;
      trow_q <= trow_d;
      tcol_q <= tcol_d;
      line_q <= line_d;
      col_q <= col_d;
      fin_q <= fin_d;
    end
  end

endmodule

>>> rtl/core/cttok_fifo.sv
// ----------------------------------------------------------------------------
// Tokenizer token queue
// Short queue of token pairs between the front end and the output stage.
// ----------------------------------------------------------------------------
module cttok_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cttok_pkg::pair_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cttok_pkg::pair_t data_o
);

  cttok_pkg::pair_t mem_q [cttok_pkg::FIFO_DEPTH];
  logic [cttok_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [cttok_pkg::FIFO_AW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (cttok_pkg::FIFO_AW + 1)'(cttok_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/cttok_out.sv
// ----------------------------------------------------------------------------
// Tokenizer output stage
// Holds one token pair and hands its tokens out one at a time.
// ----------------------------------------------------------------------------
module cttok_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_empty_i,
  input  cttok_pkg::pair_t fifo_data_i,
  output logic             fifo_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cttok_pkg::tok_t  tok_o,
  output logic             last_o
);

  logic             valid_q;
  logic             sel_q;
  cttok_pkg::pair_t pair_q;
  logic take, finishing, load;

  assign take      = valid_q && pop_i;
  assign finishing = take && (sel_q || !pair_q.two);
  assign load      = !fifo_empty_i && (!valid_q || finishing);

  assign fifo_pop_o = load;
  assign empty_o    = !valid_q;
  assign tok_o      = sel_q ? pair_q.second : pair_q.first;
  assign last_o     = sel_q || !pair_q.two;

  always_ff @(posedge clk_i) begin
    if (load) begin
      pair_q <= fifo_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sel_q <= 1'b0;
      end else if (finishing) begin
        valid_q <= 1'b0;
        sel_q <= 1'b0;
      end else if (take) begin
        sel_q <= 1'b1;
      end
    end
  end

  a_second_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && sel_q |-> pair_q.two)
    else $error("second token selected from a single-token entry");

  a_sel_clear_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> !sel_q)
    else $error("token select left set while the output stage is empty");

  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q && !fifo_empty_i |=> valid_q)
    else $error("output stage did not load a waiting token pair");

endmodule
